// File: src/pcdp_pkg.sv
// ----------------------------------------------------------------------------
// pcdp_pkg
// Shared types and constants for the delta/position PID controller.
// ----------------------------------------------------------------------------
package pcdp_pkg;

  // Gains are signed fixed point with this many fraction bits
  localparam int GAIN_FRAC_BITS = 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT   = 3'd4;
  localparam int CFG_DATA_W = 31;

  // Control mode codes
  localparam logic [1:0] MODE_DELTA    = 2'd0;
  localparam logic [1:0] MODE_POSITION = 2'd1;
  localparam logic [1:0] MODE_HOLD     = 2'd2;

  // Step kinds handed from the front to the back
  localparam logic [1:0] KIND_DELTA    = 2'd0;
  localparam logic [1:0] KIND_POSITION = 2'd1;
  localparam logic [1:0] KIND_HOLD     = 2'd2;

  // Step queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]          control_mode;
    logic signed [15:0]  gain_p;
    logic signed [15:0]  gain_i;
    logic signed [15:0]  gain_d;
    logic [30:0]         duty_limit;
  } pcdp_cfg_t;

  typedef struct packed {
    logic                clr;
    logic [1:0]          kind;
    logic                lim;
    logic signed [31:0]  opnd_p;
    logic signed [31:0]  opnd_i;
    logic signed [31:0]  opnd_d;
  } pcdp_op_t;

endpackage

// File: src/pcdp_in_if.sv
// ----------------------------------------------------------------------------
// pcdp_in_if
// Step request channel: valid/ready handshake with the step payload.
// ----------------------------------------------------------------------------
interface pcdp_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [15:0] target_value;
  logic signed [15:0] measured_value;
  logic               apply_limit;

  modport source (output valid, req_type, target_value, measured_value, apply_limit,
                  input ready);
  modport sink   (input valid, req_type, target_value, measured_value, apply_limit,
                  output ready);
endinterface

// File: src/pcdp_out_if.sv
// ----------------------------------------------------------------------------
// pcdp_out_if
// Step result channel: valid/ready handshake with the controller output.
// ----------------------------------------------------------------------------
interface pcdp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive_out;
  logic               was_clamped;

  modport source (output valid, drive_out, was_clamped, input ready);
  modport sink   (input valid, drive_out, was_clamped, output ready);
endinterface

// File: src/pcdp_front.sv
// ----------------------------------------------------------------------------
// pcdp_front
// Accepts step requests, forms the error, keeps the error history and the
// running error sum, and builds the multiplier operands for the back end.
// ----------------------------------------------------------------------------
module pcdp_front
  import pcdp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  pcdp_in_if.sink      req,
  input  logic [1:0]   control_mode,
  input  logic         queue_full,
  output logic         push,
  output pcdp_op_t     op
);

  logic signed [16:0] e1;
  logic signed [16:0] e2;
  logic signed [31:0] esum;
  logic signed [31:0] esum_next;

  logic signed [16:0] e0;
  logic signed [18:0] x0;
  logic signed [18:0] x1;
  logic signed [18:0] x2;
  logic signed [18:0] diff1;
  logic signed [18:0] diff2;
  logic signed [32:0] sum_wide;

  assign req.ready = !queue_full;
  assign push      = req.valid && !queue_full;

  always_comb begin
    e0    = 17'(req.target_value) - 17'(req.measured_value);
    x0    = 19'(e0);
    x1    = 19'(e1);
    x2    = 19'(e2);
    diff1 = x0 - x1;
    diff2 = x0 - (x1 <<< 1) + x2;

    // running sum saturates to 32 bits
    sum_wide = 33'(esum) + 33'(e0);
    if (sum_wide[32] != sum_wide[31]) begin
      esum_next = sum_wide[32] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
    end else begin
      esum_next = sum_wide[31:0];
    end

    op.clr  = req.req_type;
    op.lim  = req.apply_limit;
    op.kind = KIND_HOLD;
    op.opnd_p = '0;
    op.opnd_i = '0;
    op.opnd_d = '0;
    case (control_mode)
      MODE_DELTA: begin
        op.kind   = KIND_DELTA;
        op.opnd_p = 32'(diff1);
        op.opnd_i = 32'(e0);
        op.opnd_d = 32'(diff2);
      end
      MODE_POSITION: begin
        op.kind   = KIND_POSITION;
        op.opnd_p = 32'(e0);
        op.opnd_i = esum_next;
        op.opnd_d = 32'(diff1);
      end
      default: begin
        op.kind = KIND_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1   <= '0;
      e2   <= '0;
      esum <= '0;
    end else if (push) begin
      if (req.req_type) begin
        e1   <= '0;
        e2   <= '0;
        esum <= '0;
      end else begin
        e2 <= e1;
        e1 <= e0;
        if (control_mode == MODE_POSITION) begin
          esum <= esum_next;
        end
      end
    end
  end

endmodule

// File: src/pcdp_queue.sv
// ----------------------------------------------------------------------------
// pcdp_queue
// Small FIFO of prepared steps between the front and the back end.
// ----------------------------------------------------------------------------
module pcdp_queue
  import pcdp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pcdp_op_t  push_op,
  input  logic      pop,
  output pcdp_op_t  head,
  output logic      avail,
  output logic      full
);

  pcdp_op_t               slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign avail = (count != '0);
  assign full  = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/pcdp_back.sv
// ----------------------------------------------------------------------------
// pcdp_back
// Executes queued steps: gain multiply, term sum, then (in delta mode) accumulate
// onto the held output, with saturation and duty limit, into the result register.
// ----------------------------------------------------------------------------
module pcdp_back
  import pcdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  pcdp_cfg_t  cfg,
  input  pcdp_op_t   head,
  input  logic       avail,
  output logic       pop,
  pcdp_out_if.source rsp
);

  localparam int PROD_W = 48;
  localparam int SUM_W  = PROD_W + 2;
  localparam int ACC_W  = SUM_W + 1;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

  // multiply stage
  logic                     m_valid;
  logic                     m_clr;
  logic [1:0]               m_kind;
  logic                     m_lim;
  logic signed [PROD_W-1:0] m_tp;
  logic signed [PROD_W-1:0] m_ti;
  logic signed [PROD_W-1:0] m_td;

  // sum stage
  logic                     s_valid;
  logic                     s_clr;
  logic [1:0]               s_kind;
  logic                     s_lim;
  logic signed [SUM_W-1:0]  s_sum;

  // result register and held output
  logic                     o_valid;
  logic signed [31:0]       o_drive;
  logic                     o_clamp;
  logic signed [31:0]       held;

  logic                     advance;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [ACC_W-1:0]  acc;
  logic signed [31:0]       res;
  logic                     hit;
  logic signed [32:0]       lim_pos;
  logic signed [32:0]       lim_neg;

  assign advance     = !o_valid || rsp.ready;
  assign pop         = advance && avail;
  assign rsp.valid   = o_valid;
  assign rsp.drive_out   = o_drive;
  assign rsp.was_clamped = o_clamp;

  always_comb begin
    prod_p = PROD_W'(cfg.gain_p) * PROD_W'(head.opnd_p);
    prod_i = PROD_W'(cfg.gain_i) * PROD_W'(head.opnd_i);
    prod_d = PROD_W'(cfg.gain_d) * PROD_W'(head.opnd_d);
  end

  always_comb begin
    hit     = 1'b0;
    lim_pos = 33'({2'b00, cfg.duty_limit});
    lim_neg = -lim_pos;
    if (s_kind == KIND_DELTA) begin
      acc = ACC_W'(held) + ACC_W'(s_sum);
    end else begin
      acc = ACC_W'(s_sum);
    end
    if (s_kind == KIND_HOLD) begin
      res = held;
    end else if (acc > ACC_MAX) begin
      res = 32'(ACC_MAX);
      hit = 1'b1;
    end else if (acc < ACC_MIN) begin
      res = 32'(ACC_MIN);
      hit = 1'b1;
    end else begin
      res = acc[31:0];
    end
    if (s_lim) begin
      if (33'(res) >= lim_pos) begin
        if (33'(res) != lim_pos) begin
          hit = 1'b1;
        end
        res = lim_pos[31:0];
      end
      if (33'(res) <= lim_neg) begin
        if (33'(res) != lim_neg) begin
          hit = 1'b1;
        end
        res = lim_neg[31:0];
      end
    end
    if (s_clr) begin
      res = '0;
      hit = 1'b0;
    end
  end

  // payload registers move with the pipeline
  always_ff @(posedge clk) begin
    if (advance) begin
      m_clr  <= head.clr;
      m_kind <= head.kind;
      m_lim  <= head.lim;
      m_tp   <= prod_p >>> GAIN_FRAC_BITS;
      m_ti   <= prod_i >>> GAIN_FRAC_BITS;
      m_td   <= prod_d >>> GAIN_FRAC_BITS;

      s_clr  <= m_clr;
      s_kind <= m_kind;
      s_lim  <= m_lim;
      s_sum  <= SUM_W'(m_tp) + SUM_W'(m_ti) + SUM_W'(m_td);

      if (s_valid) begin
        o_drive <= res;
        o_clamp <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      s_valid <= 1'b0;
      o_valid <= 1'b0;
      held    <= '0;
    end else if (advance) begin
      m_valid <= avail;
      s_valid <= m_valid;
      o_valid <= s_valid;
      if (s_valid) begin
        held <= res;
      end
    end
  end

endmodule

// File: src/pid_controller_delta_position_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_delta_position_unit
// Path: step queue, multiply stage, sum stage, then the result register.
// Throughput: one step per cycle when not stalled; the result register and the
// four-entry step queue let requests keep arriving while a result waits.
// Reset: synchronous, clears error history, error sum, held output, queue
// and pipeline, and loads the register reset values.
// ----------------------------------------------------------------------------
module pid_controller_delta_position_unit
  import pcdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  pcdp_in_if.sink               req,
  pcdp_out_if.source            rsp
);

  pcdp_cfg_t cfg;
  pcdp_op_t  push_op;
  pcdp_op_t  head;
  logic      push;
  logic      pop;
  logic      avail;
  logic      full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_mode <= MODE_DELTA;
      cfg.gain_p       <= '0;
      cfg.gain_i       <= '0;
      cfg.gain_d       <= '0;
      cfg.duty_limit   <= '1;
    end else if (wr_en) begin
      case (wr_index)
        REG_CONTROL_MODE: cfg.control_mode <= wr_data[1:0];
        REG_GAIN_P:       cfg.gain_p       <= wr_data[15:0];
        REG_GAIN_I:       cfg.gain_i       <= wr_data[15:0];
        REG_GAIN_D:       cfg.gain_d       <= wr_data[15:0];
        REG_DUTY_LIMIT:   cfg.duty_limit   <= wr_data[30:0];
        default:          cfg              <= cfg;
      endcase
    end
  end

  pcdp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .control_mode (cfg.control_mode),
    .queue_full   (full),
    .push         (push),
    .op           (push_op)
  );

  pcdp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .avail   (avail),
    .full    (full)
  );

  pcdp_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (head),
    .avail (avail),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule

// File: verif/pid_controller_delta_position_unit_test.sv
// ----------------------------------------------------------------------------
// pid_controller_delta_position_unit_test
// Self-checking bench for the delta/position PID controller. A table of
// directed steps runs first. Then come an error-sum soak and random phases,
// each with fresh gains, mode and duty limit. Each result transaction is checked
// against the table's values for typed rows, else a cycle-free controller model.
// ----------------------------------------------------------------------------
module pid_controller_delta_position_unit_test;
  import pcdp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY = 3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_ITEMS = 62;
  // Steps at the widest error that build up a large error sum
  localparam int SUM_SOAK_STEPS = 14;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [30:0] DLIM_MAX = 31'h7FFF_FFFF;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               clamp;
  } ctl_result_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
    logic [30:0]        dlim;
    logic               clr;
    logic signed [15:0] tgt;
    logic signed [15:0] meas;
    logic               lim;
    logic               typed;
    logic signed [31:0] want_drive;
    logic               want_clamp;
  } step_row_t;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  pcdp_in_if  req_if ();
  pcdp_out_if rsp_if ();

  pid_controller_delta_position_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  // Controller model state and register copy
  pcdp_cfg_t          cfg_shadow;
  logic signed [16:0] hist_e1;
  logic signed [16:0] hist_e2;
  logic signed [31:0] out_held;
  logic signed [31:0] err_acc;

  ctl_result_t pending_drive[$];
  int          error_count;
  bit          idle_on;

  // Directed steps: mode, kp, ki, kd, duty limit, clear, target, measured,
  // limit, typed, expected drive, expected clamp
  step_row_t dir_tab [23] = '{
    '{MODE_DELTA, 0, 0, 0, DLIM_MAX, 0, 100, 0, 0, 1, 0, 0},
    '{MODE_DELTA, 0, 0, 0, DLIM_MAX, 0, 32767, -32768, 1, 1, 0, 0},
    '{MODE_DELTA, 0, 0, 0, DLIM_MAX, 0, -32768, 32767, 0, 1, 0, 0},
    '{MODE_DELTA, 256, 0, 0, DLIM_MAX, 0, 1000, 0, 0, 0, 0, 0},
    '{MODE_DELTA, 256, 0, 0, DLIM_MAX, 0, 1000, 0, 0, 0, 0, 0},
    '{MODE_DELTA, 256, 256, 256, DLIM_MAX, 0, 32767, -32768, 0, 0, 0, 0},
    '{MODE_DELTA, 256, 256, 256, DLIM_MAX, 0, -32768, 32767, 0, 0, 0, 0},
    '{MODE_DELTA, 32767, 32767, 32767, DLIM_MAX, 0, 32767, -32768, 0, 0, 0, 0},
    '{MODE_DELTA, -32768, -32768, -32768, DLIM_MAX, 0, 32767, -32768, 1, 0, 0, 0},
    '{MODE_DELTA, -32768, -32768, -32768, DLIM_MAX, 1, 1234, -99, 1, 1, 0, 0},
    '{MODE_POSITION, 256, 128, 64, DLIM_MAX, 0, 500, -500, 0, 0, 0, 0},
    '{MODE_POSITION, 256, 128, 64, DLIM_MAX, 0, 500, -500, 0, 0, 0, 0},
    '{MODE_POSITION, 256, 128, 64, DLIM_MAX, 0, -700, 300, 1, 0, 0, 0},
    '{MODE_POSITION, 32767, 32767, 32767, DLIM_MAX, 0, 32767, -32768, 0, 0, 0, 0},
    '{MODE_HOLD, 32767, 32767, 32767, DLIM_MAX, 0, 10, 20, 0, 0, 0, 0},
    '{MODE_HOLD, 32767, 32767, 32767, 100, 0, 1, 2, 1, 0, 0, 0},
    '{MODE_SPARE, 32767, 32767, 32767, 100, 0, 5, 5, 0, 0, 0, 0},
    '{MODE_DELTA, 256, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0},
    '{MODE_DELTA, 256, 0, 0, 0, 0, 300, 0, 1, 1, 0, 1},
    '{MODE_DELTA, 256, 0, 0, 0, 0, 300, 0, 0, 0, 0, 0},
    '{MODE_DELTA, 256, 0, 0, 1000, 0, -5000, 0, 1, 0, 0, 0},
    '{MODE_DELTA, 256, 0, 0, 1000, 0, 1000, 0, 1, 0, 0, 0},
    '{MODE_POSITION, -32768, 0, 0, DLIM_MAX, 0, -32768, 32767, 1, 0, 0, 0}
  };

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic longint scaled(input logic signed [15:0] g, input longint x);
    return (longint'(g) * x) >>> GAIN_FRAC_BITS;
  endfunction

  function automatic logic beyond32(input longint v);
    return (v > SAT_HI) || (v < SAT_LO);
  endfunction

  function automatic longint clip32(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Advance the controller model by one step and return the result
  function automatic ctl_result_t next_drive(input logic clr, input logic signed [15:0] tgt,
                                             input logic signed [15:0] meas, input logic lim);
    ctl_result_t r;
    longint      e0;
    longint      t;
    longint      res;
    longint      dl;
    logic        hit;
    hit = 1'b0;
    if (clr) begin
      hist_e1 = '0;
      hist_e2 = '0;
      out_held = '0;
      err_acc = '0;
      r.drive = '0;
      r.clamp = 1'b0;
      return r;
    end
    e0 = longint'(tgt) - longint'(meas);
    res = longint'(out_held);
    case (cfg_shadow.control_mode)
      MODE_DELTA: begin
        t = longint'(out_held) + scaled(cfg_shadow.gain_p, e0 - longint'(hist_e1))
            + scaled(cfg_shadow.gain_i, e0)
            + scaled(cfg_shadow.gain_d, e0 - 2 * longint'(hist_e1) + longint'(hist_e2));
        hit = beyond32(t);
        res = clip32(t);
      end
      MODE_POSITION: begin
        // Error sum saturates silently
        err_acc = 32'(clip32(longint'(err_acc) + e0));
        t = scaled(cfg_shadow.gain_p, e0) + scaled(cfg_shadow.gain_i, longint'(err_acc))
            + scaled(cfg_shadow.gain_d, e0 - longint'(hist_e1));
        hit = beyond32(t);
        res = clip32(t);
      end
      default: ;
    endcase
    if (lim) begin
      dl = longint'(cfg_shadow.duty_limit);
      if (res >= dl) begin
        if (res != dl) hit = 1'b1;
        res = dl;
      end
      if (res <= -dl) begin
        if (res != -dl) hit = 1'b1;
        res = -dl;
      end
    end
    out_held = 32'(res);
    hist_e2 = hist_e1;
    hist_e1 = 17'(e0);
    r.drive = out_held;
    r.clamp = hit;
    return r;
  endfunction

  function automatic logic signed [15:0] pick_gain();
    case ($urandom_range(0, 6))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sd0;
      3: return 16'sd256;
      4: return 16'($urandom_range(0, 1023)) - 16'sd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return 16'($urandom_range(0, 127)) - 16'sd64;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pcdp_cfg_t pick_config();
    pcdp_cfg_t c;
    int        m;
    m = $urandom_range(0, 7);
    c.control_mode = (m < 3) ? MODE_DELTA : (m < 6) ? MODE_POSITION :
                     (m == 6) ? MODE_HOLD : MODE_SPARE;
    c.gain_p = pick_gain();
    c.gain_i = pick_gain();
    c.gain_d = pick_gain();
    case ($urandom_range(0, 4))
      0: c.duty_limit = 31'd0;
      1: c.duty_limit = 31'($urandom_range(1, 1000));
      2: c.duty_limit = 31'($urandom);
      default: c.duty_limit = DLIM_MAX;
    endcase
    return c;
  endfunction

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
  endtask

  // Call only while the controller is idle
  task automatic apply_config(input pcdp_cfg_t c, input bit all);
    if (all || c.control_mode != cfg_shadow.control_mode)
      put_reg(REG_CONTROL_MODE, CFG_DATA_W'(c.control_mode));
    if (all || c.gain_p != cfg_shadow.gain_p) put_reg(REG_GAIN_P, {15'd0, c.gain_p});
    if (all || c.gain_i != cfg_shadow.gain_i) put_reg(REG_GAIN_I, {15'd0, c.gain_i});
    if (all || c.gain_d != cfg_shadow.gain_d) put_reg(REG_GAIN_D, {15'd0, c.gain_d});
    if (all || c.duty_limit != cfg_shadow.duty_limit) put_reg(REG_DUTY_LIMIT, c.duty_limit);
    wr_en = 1'b0;
    cfg_shadow = c;
  endtask

  task automatic settle();
    req_if.valid = 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  // Entered and left at a falling edge; valid stays high for a following step
  task automatic send_step(input logic clr, input logic signed [15:0] tgt,
                           input logic signed [15:0] meas, input logic lim,
                           input bit typed = 1'b0, input ctl_result_t want = '0);
    ctl_result_t got;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.req_type = clr;
    req_if.target_value = tgt;
    req_if.measured_value = meas;
    req_if.apply_limit = lim;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    got = next_drive(clr, tgt, meas, lim);
    pending_drive.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic run_phase(input int quota);
    int                 sent;
    int                 len;
    int                 kind;
    logic signed [15:0] tgt;
    logic signed [15:0] meas;
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        // Hold a steady error so the output winds up toward saturation
        len = $urandom_range(4, 50);
        if (len > quota - sent) len = quota - sent;
        tgt = pick_value();
        meas = pick_value();
        repeat (len) send_step(1'b0, tgt, meas, 1'($urandom_range(0, 1)));
        sent += len;
      end else if (kind < 8) begin
        len = $urandom_range(1, 10);
        if (len > quota - sent) len = quota - sent;
        repeat (len) send_step(1'b0, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
        sent += len;
      end else if (kind == 8) begin
        send_step(1'b1, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        // Swing between the extremes to stress the difference terms
        len = $urandom_range(2, 12);
        if (len > quota - sent) len = quota - sent;
        for (int i = 0; i < len; i++) begin
          if (i % 2 == 0) send_step(1'b0, 16'sh7FFF, 16'sh8000, 1'($urandom_range(0, 1)));
          else send_step(1'b0, 16'sh8000, 16'sh7FFF, 1'($urandom_range(0, 1)));
        end
        sent += len;
      end
    end
  endtask

  // Result receiver with random stall bursts
  initial begin : rsp_ready_gen
    int stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp_if.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    ctl_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_drive.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual drive_out %0d was_clamped %0b",
                 $time, rsp_if.drive_out, rsp_if.was_clamped);
        error_count++;
      end else begin
        want = pending_drive.pop_front();
        if (rsp_if.drive_out !== want.drive) begin
          $display("%0t: drive_out mismatch: expected %0d, actual %0d",
                   $time, want.drive, rsp_if.drive_out);
          error_count++;
        end
        if (rsp_if.was_clamped !== want.clamp) begin
          $display("%0t: was_clamped mismatch: expected %0b, actual %0b",
                   $time, want.clamp, rsp_if.was_clamped);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog expired with %0d results outstanding", $time, pending_drive.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    pcdp_cfg_t c;
    error_count = 0;
    idle_on = 1'b1;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    req_if.valid = 1'b0;
    req_if.req_type = 1'b0;
    req_if.target_value = '0;
    req_if.measured_value = '0;
    req_if.apply_limit = 1'b0;
    cfg_shadow = '{MODE_DELTA, 16'sd0, 16'sd0, 16'sd0, DLIM_MAX};
    hist_e1 = '0;
    hist_e2 = '0;
    out_held = '0;
    err_acc = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    for (int r = 0; r < $size(dir_tab); r++) begin
      c = '{dir_tab[r].mode, dir_tab[r].kp, dir_tab[r].ki, dir_tab[r].kd, dir_tab[r].dlim};
      if (c != cfg_shadow) begin
        settle();
        apply_config(c, 1'b0);
      end
      send_step(dir_tab[r].clr, dir_tab[r].tgt, dir_tab[r].meas, dir_tab[r].lim,
                dir_tab[r].typed, '{dir_tab[r].want_drive, dir_tab[r].want_clamp});
    end

    // Build up the error sum, then back off it
    settle();
    c = pick_config();
    c.control_mode = MODE_POSITION;
    apply_config(c, 1'b1);
    idle_on = 1'b0;
    send_step(1'b1, 16'sd0, 16'sd0, 1'b0);
    repeat (SUM_SOAK_STEPS) send_step(1'b0, 16'sh7FFF, 16'sh8000, 1'($urandom_range(0, 1)));
    repeat (20) send_step(1'b0, 16'sh8000, 16'sh7FFF, 1'($urandom_range(0, 1)));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      idle_on = (p < RANDOM_PHASES - 2);
      apply_config(pick_config(), 1'b1);
      run_phase(PHASE_ITEMS);
    end

    settle();
    repeat (PIPE_LATENCY * 4) @(posedge clk);
    if (pending_drive.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_drive.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
